FILE: rtl/ntc_pkg.sv
package ntc_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_ZERO    = 3'd2,
    ST_BAD_DEN = 3'd3,
    ST_SAT     = 3'd4
  } status_e;

  // Configuration register indexes
  localparam logic [2:0] CFG_SERIES_R = 3'd0;
  localparam logic [2:0] CFG_COEFF_A  = 3'd1;
  localparam logic [2:0] CFG_COEFF_B  = 3'd2;
  localparam logic [2:0] CFG_COEFF_C  = 3'd3;
  localparam logic [2:0] CFG_KELVIN   = 3'd4;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 36;

  // Register reset values
  localparam logic [23:0]        RST_SERIES_R = 24'd100000;
  localparam logic signed [35:0] RST_COEFF_A  = 36'sd854205266;
  localparam logic signed [35:0] RST_COEFF_B  = 36'sd227465515;
  localparam logic signed [35:0] RST_COEFF_C  = 36'sd140747;
  localparam logic [15:0]        RST_KELVIN   = 16'd27315;

  // ln(2) in Q24
  localparam logic [24:0] LN2_Q24 = 25'd11629080;

  // Datapath widths, sized for the widest converter setting
  localparam int unsigned M_W      = 31;  // Q30 mantissa
  localparam int unsigned FRAC_W   = 32;  // log2 fraction bits
  localparam int unsigned L20_W    = 27;  // ln in Q20
  localparam int unsigned L2_W     = 32;  // ln^2 in Q20, never negative
  localparam int unsigned L3_W     = 30;  // ln^3 in Q12
  localparam int unsigned BL_W     = 43;  // B*ln in Q40
  localparam int unsigned CL_W     = 54;  // C*ln^3 in Q40
  localparam int unsigned S_W      = 56;  // Steinhart-Hart sum
  localparam int unsigned US_W     = 55;  // positive sum magnitude
  localparam int unsigned Q_W      = 17;  // quotient bits kept
  localparam int unsigned RW       = 73;  // divider remainder width

  // 100 * 2^40, numerator base of the reciprocal in centi-kelvin
  localparam logic [S_W-1:0] NUM_BASE = 56'd109951162777600;

  typedef logic [2:0] status_t;

endpackage

FILE: rtl/ntc_adc_to_celsius_unit.sv
// Channel | direction | handshake               | beat payload
// in      | input     | in_valid_i / in_ready_o  | adc_code_i
// out     | output    | out_valid_o / out_ready_i| temp_centi_c_o, status_o
// cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// Fully pipelined: one beat in and one beat out per cycle while out_ready_i is high.
// Most of the pipeline depth is the 32-stage squaring log2 (one squarer per fraction bit)
// and the 17-stage restoring reciprocal divider.
// Reset clears the valid bits and loads the register defaults; no sweep.
// Each stage loads when it is empty or the next stage moves, so bubbles
// collapse and a stalled output never drops or repeats a beat.
module ntc_adc_to_celsius_unit
  import ntc_pkg::*;
#(
  parameter int unsigned ADC_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [ADC_BITS-1:0]   adc_code_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [15:0]    temp_centi_c_o,
  output logic [2:0]            status_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned PW   = ADC_BITS + 24;
  localparam int unsigned KW   = $clog2(PW);
  localparam int unsigned LG_W = KW + FRAC_W;
  localparam int unsigned D_W  = LG_W + 1;
  localparam logic [ADC_BITS-1:0] FULL = {ADC_BITS{1'b1}};

  // Stage map
  localparam int unsigned LOG_N  = FRAC_W;
  localparam int unsigned S_IN   = 0;
  localparam int unsigned S_LZ   = 1;
  localparam int unsigned S_NRM  = 2;
  localparam int unsigned S_LOG0 = 3;
  localparam int unsigned S_D    = S_LOG0 + LOG_N;
  localparam int unsigned S_L20  = S_D + 1;
  localparam int unsigned S_L2   = S_D + 2;
  localparam int unsigned S_L3   = S_D + 3;
  localparam int unsigned S_PR   = S_D + 4;
  localparam int unsigned S_SUM  = S_D + 5;
  localparam int unsigned S_NUM  = S_D + 6;
  localparam int unsigned S_DIV0 = S_D + 7;
  localparam int unsigned S_OUT  = S_DIV0 + Q_W;
  localparam int unsigned NST    = S_OUT + 1;

  // ---------------- configuration registers ----------------
  logic [23:0]        series_r_q;
  logic signed [35:0] coeff_a_q, coeff_b_q, coeff_c_q;
  logic [15:0]        kelvin_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      series_r_q <= RST_SERIES_R;
      coeff_a_q  <= RST_COEFF_A;
      coeff_b_q  <= RST_COEFF_B;
      coeff_c_q  <= RST_COEFF_C;
      kelvin_q   <= RST_KELVIN;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SERIES_R: series_r_q <= cfg_data_i[23:0];
        CFG_COEFF_A:  coeff_a_q  <= $signed(cfg_data_i);
        CFG_COEFF_B:  coeff_b_q  <= $signed(cfg_data_i);
        CFG_COEFF_C:  coeff_c_q  <= $signed(cfg_data_i);
        CFG_KELVIN:   kelvin_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic [NST-1:0] vld_q;
  logic [NST-1:0] ld;
  status_t        st_q   [NST];
  status_t        st_nxt [NST];

  always_comb begin
    ld[NST-1] = !vld_q[NST-1] || out_ready_i;
    for (int j = NST - 2; j >= 0; j--) begin
      ld[j] = !vld_q[j] || ld[j+1];
    end
  end

  assign in_ready_o = ld[S_IN];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (ld[S_IN]) vld_q[S_IN] <= in_valid_i;
      for (int j = 1; j < NST; j++) begin
        if (ld[j]) vld_q[j] <= vld_q[j-1];
      end
    end
  end

  // Status travels with the beat
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < NST; j++) begin
      if (ld[j]) st_q[j] <= st_nxt[j];
    end
  end

  // ---------------- stage IN: resistance ratio terms ----------------
  logic [PW-1:0] prod_q, den_q;
  status_t       st_in;

  always_comb begin
    if (adc_code_i == FULL) begin
      st_in = ST_FULL;
    end else if (adc_code_i == '0 || series_r_q == '0) begin
      st_in = ST_ZERO;
    end else begin
      st_in = ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[S_IN]) begin
      prod_q <= PW'(adc_code_i) * PW'(series_r_q);
      den_q  <= PW'(FULL - adc_code_i);
    end
  end

  // ---------------- stage LZ: leading one ----------------
  function automatic logic [KW-1:0] msb_idx(input logic [PW-1:0] x);
    logic [KW-1:0] r;
    r = '0;
    for (int i = 0; i < PW; i++) begin
      if (x[i]) r = KW'(i);
    end
    return r;
  endfunction

  logic [PW-1:0] x_q   [2];
  logic [KW-1:0] kz_q  [2];

  always_ff @(posedge clk_i) begin
    if (ld[S_LZ]) begin
      x_q[0]  <= prod_q;
      x_q[1]  <= den_q;
      kz_q[0] <= msb_idx(prod_q);
      kz_q[1] <= msb_idx(den_q);
    end
  end

  // ---------------- stage NRM + LOG: log2 by squaring ----------------
  logic [M_W-1:0]    lm_q [LOG_N+1][2];
  logic [FRAC_W-1:0] lf_q [LOG_N+1][2];
  logic [KW-1:0]     lk_q [LOG_N+1][2];

  for (genvar g = 0; g < 2; g++) begin : g_opnd
    logic [PW+29:0] nrm_ext;
    assign nrm_ext = {x_q[g], 30'b0} >> kz_q[g];

    always_ff @(posedge clk_i) begin
      if (ld[S_NRM]) begin
        lm_q[0][g] <= nrm_ext[M_W-1:0];
        lf_q[0][g] <= '0;
        lk_q[0][g] <= kz_q[g];
      end
    end

    // One fraction bit per stage
    for (genvar j = 0; j < LOG_N; j++) begin : g_log
      logic [2*M_W-1:0] sq;
      logic [M_W:0]     t;
      assign sq = (2*M_W)'(lm_q[j][g]) * (2*M_W)'(lm_q[j][g]);
      assign t  = sq[30 +: M_W+1];

      always_ff @(posedge clk_i) begin
        if (ld[S_LOG0+j]) begin
          lm_q[j+1][g] <= t[M_W] ? t[M_W:1] : t[M_W-1:0];
          lf_q[j+1][g] <= lf_q[j][g] | (FRAC_W'(t[M_W]) << (FRAC_W-1-j));
          lk_q[j+1][g] <= lk_q[j][g];
        end
      end
    end
  end

  // ---------------- stage D: log difference ----------------
  logic signed [D_W-1:0] d_q;

  always_ff @(posedge clk_i) begin
    if (ld[S_D]) begin
      d_q <= $signed({1'b0, lk_q[LOG_N][0], lf_q[LOG_N][0]})
           - $signed({1'b0, lk_q[LOG_N][1], lf_q[LOG_N][1]});
    end
  end

  // ---------------- stage L20: natural log in Q20 ----------------
  logic signed [D_W+24:0]   p_ln;
  logic signed [L20_W-1:0]  l20_q [3];

  assign p_ln = d_q * $signed({1'b0, LN2_Q24});

  always_ff @(posedge clk_i) begin
    if (ld[S_L20]) l20_q[0] <= p_ln[36 +: L20_W];
  end

  // ---------------- stage L2: ln^2 ----------------
  logic signed [2*L20_W-1:0] p_l2;
  logic [L2_W-1:0]           l2_q;

  assign p_l2 = l20_q[0] * l20_q[0];

  always_ff @(posedge clk_i) begin
    if (ld[S_L2]) begin
      l2_q     <= p_l2[20 +: L2_W];
      l20_q[1] <= l20_q[0];
    end
  end

  // ---------------- stage L3: ln^3 ----------------
  logic signed [L2_W+L20_W:0] p_l3;
  logic signed [L3_W-1:0]     l3_q;

  assign p_l3 = $signed({1'b0, l2_q}) * l20_q[1];

  always_ff @(posedge clk_i) begin
    if (ld[S_L3]) begin
      l3_q     <= p_l3[28 +: L3_W];
      l20_q[2] <= l20_q[1];
    end
  end

  // ---------------- stage PR: coefficient products ----------------
  logic signed [36+L20_W-1:0] p_b;
  logic signed [36+L3_W-1:0]  p_c;
  logic signed [BL_W-1:0]     bl_q;
  logic signed [CL_W-1:0]     cl_q;

  assign p_b = coeff_b_q * l20_q[2];
  assign p_c = coeff_c_q * l3_q;

  always_ff @(posedge clk_i) begin
    if (ld[S_PR]) begin
      bl_q <= p_b[20 +: BL_W];
      cl_q <= p_c[12 +: CL_W];
    end
  end

  // ---------------- stage SUM: Steinhart-Hart sum ----------------
  logic signed [S_W-1:0] s_q;

  always_ff @(posedge clk_i) begin
    if (ld[S_SUM]) s_q <= S_W'(coeff_a_q) + S_W'(bl_q) + S_W'(cl_q);
  end

  // ---------------- stage NUM: numerator, range check ----------------
  logic [US_W-1:0] us_nxt;
  logic [S_W-1:0]  num_nxt;
  logic [US_W-1:0] us_q  [Q_W+1];
  logic [RW-1:0]   rem_q [Q_W+1];
  logic [Q_W-1:0]  q_q   [Q_W+1];
  logic            big_q [Q_W+1];

  assign us_nxt  = s_q[US_W-1:0];
  assign num_nxt = NUM_BASE + S_W'(us_nxt >> 1);

  always_ff @(posedge clk_i) begin
    if (ld[S_NUM]) begin
      us_q[0]  <= us_nxt;
      rem_q[0] <= RW'(num_nxt);
      q_q[0]   <= '0;
      big_q[0] <= RW'(num_nxt) >= RW'({us_nxt, {Q_W{1'b0}}});
    end
  end

  // ---------------- stage DIV: restoring divider, one bit per stage ----------------
  for (genvar j = 0; j < Q_W; j++) begin : g_div
    localparam int unsigned BIT = Q_W - 1 - j;
    logic [RW-1:0] dv;
    logic          ge;
    assign dv = RW'(us_q[j]) << BIT;
    assign ge = rem_q[j] >= dv;

    always_ff @(posedge clk_i) begin
      if (ld[S_DIV0+j]) begin
        rem_q[j+1] <= ge ? rem_q[j] - dv : rem_q[j];
        q_q[j+1]   <= q_q[j] | (Q_W'(ge) << BIT);
        us_q[j+1]  <= us_q[j];
        big_q[j+1] <= big_q[j];
      end
    end
  end

  // ---------------- stage OUT: offset and saturation ----------------
  logic signed [Q_W+1:0] diff;
  logic signed [15:0]    temp_nxt;
  logic signed [15:0]    temp_q;

  assign diff = $signed({2'b0, q_q[Q_W]}) - $signed((Q_W+2)'(kelvin_q));

  always_comb begin
    st_nxt[S_IN] = st_in;
    for (int j = 1; j < NST; j++) begin
      st_nxt[j] = st_q[j-1];
    end
    // Non-positive sum has no reciprocal
    if (st_q[S_NUM-1] == ST_OK && s_q <= 0) st_nxt[S_NUM] = ST_BAD_DEN;

    temp_nxt = '0;
    if (st_q[S_OUT-1] == ST_OK) begin
      if (big_q[Q_W] || diff > 32767) begin
        temp_nxt = 16'sh7fff;
        st_nxt[S_OUT] = ST_SAT;
      end else if (diff < -32768) begin
        temp_nxt = -16'sh8000;
        st_nxt[S_OUT] = ST_SAT;
      end else begin
        temp_nxt = diff[15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[S_OUT]) temp_q <= temp_nxt;
  end

  assign out_valid_o    = vld_q[S_OUT];
  assign temp_centi_c_o = temp_q;
  assign status_o       = st_q[S_OUT];

  // ---------------- assertions ----------------
  a_err_zero_temp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL || status_o == ST_ZERO ||
                    status_o == ST_BAD_DEN) |-> temp_centi_c_o == 16'sd0)
    else $error("error status with nonzero temperature");

  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_SAT |->
      temp_centi_c_o == 16'sh7fff || temp_centi_c_o == -16'sh8000)
    else $error("saturated beat not at a bound");

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output stage");

  a_full_code_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && adc_code_i == FULL |=>
      vld_q[S_IN] && st_q[S_IN] == ST_FULL)
    else $error("full-scale code not flagged");

endmodule

FILE: tb/ntc_adc_to_celsius_unit_tb.sv
`timescale 1ns / 1ps

module ntc_adc_to_celsius_unit_tb;

  localparam int unsigned  FULL_CODE = 4095;
  localparam longint       K_LN2     = 64'sd11629080;  // ln(2) in Q24
  localparam longint       MAX_36    = 64'sd34359738367;
  localparam longint       MIN_36    = -64'sd34359738368;

  typedef struct {
    logic signed [15:0]  temp;
    ntc_pkg::status_e    st;
  } reading_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [11:0] adc_code_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic signed [15:0] temp_centi_c_o;
  logic [2:0]  status_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [35:0] cfg_data_i = '0;

  // Shadow copy of the conversion registers
  longint unsigned series_r = 100000;
  longint          coef_a = 854205266;
  longint          coef_b = 227465515;
  longint          coef_c = 140747;
  longint          kelvin = 27315;

  // Directed codes: end points, midscale and bit patterns
  int unsigned dir_codes [12] = '{0, 1, 2, 4095, 4094, 2048, 2047, 12'hAAA, 12'h555,
                                  1000, 3000, 100};

  logic [11:0] code_q[$];
  reading_t    reading_q[$];
  int          tx_gap = 0;
  int          rx_stall = 0;
  bit          tx_fast = 1'b0;
  bit          rx_hold = 1'b0;
  bit          hold_go = 1'b0;
  int          n_err = 0;
  int          n_in = 0;
  int          n_out = 0;
  int          n_sets = 1;

  ntc_adc_to_celsius_unit u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .adc_code_i,
    .out_valid_o, .out_ready_i, .temp_centi_c_o, .status_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #10 clk_i = ~clk_i;

  // log2 in Q32: Q30 mantissa, fraction bits by repeated squaring
  function automatic longint unsigned log2_q32(longint unsigned x);
    int unsigned     k;
    longint unsigned m;
    longint unsigned frac;
    k = 0;
    frac = 0;
    for (int i = 0; i < 64; i++) if (x[i]) k = i;
    m = (k >= 30) ? (x >> (k - 30)) : (x << (30 - k));
    for (int i = 0; i < 32; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac[31-i] = 1'b1;
      end
    end
    return (longint'(k) << 32) | frac;
  endfunction

  // Steinhart-Hart conversion of one code under the current registers
  function automatic reading_t convert(logic [11:0] code);
    reading_t        r;
    longint          d, l20, l2, l3, s, t;
    longint unsigned tk;
    r.temp = '0;
    r.st = ntc_pkg::ST_OK;
    if (code == FULL_CODE) begin
      r.st = ntc_pkg::ST_FULL;
    end else if (code == 0 || series_r == 0) begin
      r.st = ntc_pkg::ST_ZERO;
    end else begin
      d = longint'(log2_q32(longint'(code) * series_r))
        - longint'(log2_q32(longint'(FULL_CODE - code)));
      l20 = (d * K_LN2) >>> 36;
      l2 = (l20 * l20) >>> 20;
      l3 = (l2 * l20) >>> 28;
      s = coef_a + ((coef_b * l20) >>> 20) + ((coef_c * l3) >>> 12);
      if (s <= 0) begin
        r.st = ntc_pkg::ST_BAD_DEN;
      end else begin
        tk = ((64'd100 << 40) + (longint'(s) >> 1)) / longint'(s);
        t = longint'(tk) - kelvin;
        if (t > 32767) begin
          t = 32767;
          r.st = ntc_pkg::ST_SAT;
        end else if (t < -32768) begin
          t = -32768;
          r.st = ntc_pkg::ST_SAT;
        end
        r.temp = t[15:0];
      end
    end
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("ERROR t=%0t beat %0d: %s got %0d want %0d", $time, n_out, what, got, want);
    n_err++;
  endtask

  // Input driver: one code per beat, random gap between beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        reading_q.push_back(convert(adc_code_i));
        n_in++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          in_valid_i <= 1'b0;
        end else if (code_q.size() > 0) begin
          in_valid_i <= 1'b1;
          adc_code_i <= code_q.pop_front();
          tx_gap <= (tx_fast || $urandom_range(0, 2) != 0) ? 0 : $urandom_range(0, 15);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: check each beat against the oldest expected reading
  always @(posedge clk_i or negedge rst_ni) begin
    reading_t e;
    int       draw;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (reading_q.size() == 0) begin
          report("unexpected beat", longint'(status_o), 0);
        end else begin
          e = reading_q.pop_front();
          if (temp_centi_c_o !== e.temp)
            report("temp", longint'(temp_centi_c_o), longint'(e.temp));
          if (status_o !== e.st) report("status", longint'(status_o), longint'(e.st));
        end
        n_out++;
      end
      draw = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : 0;
      if (rx_hold) begin
        out_ready_i <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall <= rx_stall - 1;
        out_ready_i <= 1'b0;
      end else if (out_valid_o && out_ready_i && draw > 0) begin
        rx_stall <= draw - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Long receiver hold-off so the pipeline fills and backs up
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  task automatic write_reg(logic [2:0] idx, logic [35:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      ntc_pkg::CFG_SERIES_R: series_r = data[23:0];
      ntc_pkg::CFG_COEFF_A:  coef_a = $signed(data);
      ntc_pkg::CFG_COEFF_B:  coef_b = $signed(data);
      ntc_pkg::CFG_COEFF_C:  coef_c = $signed(data);
      ntc_pkg::CFG_KELVIN:   kelvin = data[15:0];
      default: ;
    endcase
  endtask

  task automatic write_all(longint r, longint a, longint b, longint c, longint k);
    write_reg(ntc_pkg::CFG_SERIES_R, 36'(r));
    write_reg(ntc_pkg::CFG_COEFF_A, 36'(a));
    write_reg(ntc_pkg::CFG_COEFF_B, 36'(b));
    write_reg(ntc_pkg::CFG_COEFF_C, 36'(c));
    write_reg(ntc_pkg::CFG_KELVIN, 36'(k));
    n_sets++;
  endtask

  task automatic wait_idle();
    while (code_q.size() > 0 || in_valid_i || reading_q.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly in-range codes, with the end points mixed in
  task automatic run_codes(int n);
    int p;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 19);
      if (p == 0) code_q.push_back(12'd0);
      else if (p == 1) code_q.push_back(12'(FULL_CODE));
      else if (p == 2) code_q.push_back(12'($urandom));
      else code_q.push_back(12'($urandom_range(1, FULL_CODE - 1)));
    end
    wait_idle();
  endtask

  function automatic longint rand36();
    return longint'($signed(36'({$urandom_range(0, 15), $urandom})));
  endfunction

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed codes under reset defaults
    foreach (dir_codes[i]) code_q.push_back(12'(dir_codes[i]));
    wait_idle();

    // Backpressure: full-rate sender against a stalled receiver
    tx_fast = 1'b1;
    hold_go = 1'b1;
    run_codes(190);
    tx_fast = 1'b0;

    // Unused register indexes must be ignored
    for (int i = 5; i < 8; i++) write_reg(3'(i), 36'($urandom));

    // Smallest nonzero divider resistor, no kelvin offset
    write_all(1, 854205266, 227465515, 140747, 0);
    run_codes(45);
    // Largest resistor and offset
    write_all(16777215, 854205266, 227465515, 140747, 65535);
    run_codes(45);
    // Tiny sum: far above the positive limit
    write_all(100000, 1, 0, 0, 27315);
    run_codes(30);
    // Coefficient extremes
    write_all(100000, MAX_36, MIN_36, MAX_36, 27315);
    run_codes(40);
    write_all(10000, MIN_36, MAX_36, MIN_36, 0);
    run_codes(40);
    // Near-default coefficients with random resistor and offset
    write_all($urandom_range(1, 16777215), 854205266 + $signed($urandom_range(0, 65535)),
              227465515, 140747 + $urandom_range(0, 4095), $urandom_range(0, 65535));
    run_codes(50);
    // Fully random register sets
    for (int p = 0; p < 2; p++) begin
      write_all($urandom_range(0, 16777215), rand36(), rand36(), rand36(),
                $urandom_range(0, 65535));
      run_codes(50);
    end

    repeat (70) @(posedge clk_i);
    $display("Ran %0d codes over %0d register sets, %0d readings checked.",
             n_in, n_sets, n_out);
    if (n_err == 0 && reading_q.size() == 0) begin
      $display("ntc_adc_to_celsius_unit: match");
    end else begin
      $display("ntc_adc_to_celsius_unit: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("TIMEOUT");
    $display("ntc_adc_to_celsius_unit: mismatch");
    $finish;
  end

endmodule
